[rtl/core/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 64;
    localparam int SET_W    = 6;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAYS     = 8;
    localparam int WAY_W    = 3;
    localparam int RANK_W   = 3;
    localparam int CNT_W    = 32;

    localparam logic [2:0]        SET_BITS_MAX = 3'(SET_W);
    localparam logic [3:0]        WAYS_MAX     = 4'(WAYS);
    localparam logic [RANK_W-1:0] RANK_MAX     = RANK_W'(WAYS - 1);

    // access kinds
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    // access outcomes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             extra_hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } out_item_t;

    // one RAM row holds every way of a set
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][RANK_W-1:0] rank;
        logic [WAYS-1:0][TAG_W-1:0]  tag;
    } set_row_t;

    typedef struct packed {
        logic [1:0] outcome;
        set_row_t   row;
    } lookup_res_t;

endpackage

[rtl/core/salc_set_ram.sv]
// ----------------------------------------------------------------------------
// salc_set_ram
// Set storage: one row per set, registered read, one write port.
// A per-row flag cleared at reset makes an unwritten row read as all invalid.
// ----------------------------------------------------------------------------
module salc_set_ram
    import salc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output set_row_t         rd_row,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  set_row_t         wr_row
);

    set_row_t             mem [NUM_SETS];
    logic [NUM_SETS-1:0]  row_written_reg;
    set_row_t             rd_data_reg;
    logic                 rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_written_reg <= '0;
            rd_ok_reg       <= 1'b0;
        end else begin
            if (wr_en) begin
                row_written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= row_written_reg[rd_addr];
            end
        end
    end

    always_comb begin
        rd_row       = rd_data_reg;
        rd_row.valid = rd_data_reg.valid & {WAYS{rd_ok_reg}};
    end

endmodule

[rtl/core/salc_lookup.sv]
// ----------------------------------------------------------------------------
// salc_lookup
// Tag compare over all active ways, way selection (hit, empty fill or LRU
// victim) and the recency update of the set row.
// ----------------------------------------------------------------------------
module salc_lookup
    import salc_pkg::*;
(
    input  set_row_t         row,
    input  logic [TAG_W-1:0] tag,
    input  logic [3:0]       ways_eff,
    output lookup_res_t      res
);

    logic [WAYS-1:0]   active;
    logic [WAYS-1:0]   live;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              has_empty;
    logic [WAY_W-1:0]  empty_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  sel_way;
    logic [RANK_W:0]   old_rank;

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        has_empty = 1'b0;
        empty_way = '0;
        victim    = '0;
        for (int k = 0; k < WAYS; k++) begin
            active[k] = (4'(k) < ways_eff);
            live[k]   = active[k] & row.valid[k];
        end
        for (int k = 0; k < WAYS; k++) begin
            if (live[k]) begin
                if (!hit && row.tag[k] == tag) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(k);
                end
            end else if (active[k] && !has_empty) begin
                has_empty = 1'b1;
                empty_way = WAY_W'(k);
            end
        end
        // highest rank wins, lowest way on a tie
        for (int k = 1; k < WAYS; k++) begin
            if (active[k] && row.rank[k] > row.rank[victim]) begin
                victim = WAY_W'(k);
            end
        end

        if (hit) begin
            sel_way     = hit_way;
            res.outcome = OUT_HIT;
        end else if (has_empty) begin
            sel_way     = empty_way;
            res.outcome = OUT_MISS;
        end else begin
            sel_way     = victim;
            res.outcome = OUT_EVICT;
        end

        // a fresh fill ages every live line not already at the top rank
        if (!hit && has_empty) begin
            old_rank = (RANK_W+1)'(WAYS);
        end else begin
            old_rank = {1'b0, row.rank[sel_way]};
        end

        res.row = row;
        for (int k = 0; k < WAYS; k++) begin
            if (WAY_W'(k) != sel_way && live[k] && {1'b0, row.rank[k]} < old_rank
                    && row.rank[k] != RANK_MAX) begin
                res.row.rank[k] = row.rank[k] + 1'b1;
            end
        end
        res.row.rank[sel_way]  = '0;
        res.row.valid[sel_way] = 1'b1;
        res.row.tag[sel_way]   = tag;
    end

endmodule

[rtl/core/set_assoc_lru_cache_tracker.sv]
// Flow: the set row is registered at the accepting edge; the lookup result is then
// registered into the output register once it is free or being drained, raising m_valid.
// Accesses: a new access is accepted only after the last one finishes the read-modify-write
// of its set row (registered read, then write back); a stalled result holds the lookup state.
// Reset: synchronous, clears counters and the per-set written flags and loads the default
// configuration at once; no clearing pass, the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker
// Set-associative cache model with LRU replacement and running hit, miss and
// eviction counts.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker
    import salc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic              state_reg;
    logic [2:0]        set_bits_reg;
    logic [5:0]        offset_bits_reg;
    logic [3:0]        ways_reg;
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [CNT_W-1:0]  evict_cnt_reg;
    logic              m_valid_reg;
    out_item_t         out_reg;

    logic [2:0]        sbits_eff;
    logic [3:0]        ways_eff;
    logic              accept;
    logic [ADDR_W-1:0] set_shift;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  set_idx;
    logic [6:0]        tag_shamt;
    logic [TAG_W-1:0]  tag;
    set_row_t          rd_row;
    lookup_res_t       lk_res;
    logic              lk_done;
    logic [1:0]        hit_inc;
    logic              miss_inc;
    logic              evict_inc;
    logic [CNT_W:0]    hit_sum;
    logic [CNT_W:0]    miss_sum;
    logic [CNT_W:0]    evict_sum;
    logic [CNT_W-1:0]  hit_cnt_next;
    logic [CNT_W-1:0]  miss_cnt_next;
    logic [CNT_W-1:0]  evict_cnt_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign sbits_eff = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_reg;
    always_comb begin
        if (ways_reg == 4'd0) begin
            ways_eff = 4'd1;
        end else if (ways_reg > WAYS_MAX) begin
            ways_eff = WAYS_MAX;
        end else begin
            ways_eff = ways_reg;
        end
    end

    assign set_shift = s_data.address >> offset_bits_reg;
    assign set_mask  = ~({SET_W{1'b1}} << sbits_eff);
    assign set_idx   = set_shift[SET_W-1:0] & set_mask;

    // the user must keep config stable while an access is in flight; the block does not enforce it
    assign tag_shamt = {1'b0, offset_bits_reg} + {4'b0, sbits_eff};
    assign tag       = tag_shamt[6] ? '0 : (addr_reg >> tag_shamt[5:0]);

    salc_set_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (set_idx),
        .rd_row  (rd_row),
        .wr_en   (lk_done),
        .wr_addr (set_reg),
        .wr_row  (lk_res.row)
    );

    salc_lookup u_lookup (
        .row      (rd_row),
        .tag      (tag),
        .ways_eff (ways_eff),
        .res      (lk_res)
    );

    // finish only when the output register is free or being drained
    assign lk_done = (state_reg == ST_LOOK) && (!m_valid_reg || m_ready);

    assign hit_inc   = {1'b0, lk_res.outcome == OUT_HIT} + {1'b0, mode_reg == MODE_MODIFY};
    assign miss_inc  = (lk_res.outcome != OUT_HIT);
    assign evict_inc = (lk_res.outcome == OUT_EVICT);

    assign hit_sum   = {1'b0, hit_cnt_reg} + {{(CNT_W-1){1'b0}}, hit_inc};
    assign miss_sum  = {1'b0, miss_cnt_reg} + {{CNT_W{1'b0}}, miss_inc};
    assign evict_sum = {1'b0, evict_cnt_reg} + {{CNT_W{1'b0}}, evict_inc};

    assign hit_cnt_next   = hit_sum[CNT_W]   ? {CNT_W{1'b1}} : hit_sum[CNT_W-1:0];
    assign miss_cnt_next  = miss_sum[CNT_W]  ? {CNT_W{1'b1}} : miss_sum[CNT_W-1:0];
    assign evict_cnt_next = evict_sum[CNT_W] ? {CNT_W{1'b1}} : evict_sum[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            set_bits_reg    <= 3'd1;
            offset_bits_reg <= 6'd8;
            ways_reg        <= 4'd1;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            evict_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_WAYS:        ways_reg        <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                state_reg <= ST_LOOK;
            end else if (lk_done) begin
                state_reg <= ST_IDLE;
            end
            if (lk_done) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_data.mode;
            addr_reg <= s_data.address;
            set_reg  <= set_idx;
        end
        if (lk_done) begin
            out_reg.outcome        <= lk_res.outcome;
            out_reg.extra_hit      <= (mode_reg == MODE_MODIFY);
            out_reg.hit_total      <= hit_cnt_next;
            out_reg.miss_total     <= miss_cnt_next;
            out_reg.eviction_total <= evict_cnt_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        lk_done |=> m_valid_reg)
        else $error("result not presented after lookup");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) && !lk_done |=> (state_reg == ST_LOOK))
        else $error("stalled lookup dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        evict_cnt_reg <= miss_cnt_reg)
        else $error("evictions exceed misses");

    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (miss_cnt_reg >= $past(miss_cnt_reg)))
        else $error("miss count went backwards");
`endif

endmodule
